// File: rtl/core/lru_pr_pkg.sv
`timescale 1ns / 1ps

package lru_pr_pkg;

  // Per-request controls broadcast to every cell of the recency row
  typedef struct packed {
    logic en;      // a request is accepted this cycle
    logic hit;     // the page is resident
    logic evict;   // miss with all frames in use
    logic append;  // miss with a free frame
  } lru_ctrl_t;

  localparam int unsigned FrameCountW = 4;
  localparam int unsigned FaultCountW = 16;
  localparam logic [FrameCountW-1:0] FrameCountReset = FrameCountW'(3);

endpackage

// File: rtl/core/lru_pr_cell.sv
`timescale 1ns / 1ps

module lru_pr_cell #(
  parameter int unsigned PAGE_BITS = 8,
  parameter int unsigned OCC_W     = 4,
  parameter int unsigned IDX       = 0
) (
  input  logic                 clk_i,
  input  lru_pr_pkg::lru_ctrl_t ctrl_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  logic [OCC_W-1:0]     occ_i,
  input  logic [PAGE_BITS-1:0] upper_page_i,
  input  logic                 seen_i,
  output logic                 seen_o,
  output logic                 match_o,
  output logic [PAGE_BITS-1:0] page_o
);
  import lru_pr_pkg::*;

  localparam logic [OCC_W-1:0] IdxC   = OCC_W'(IDX);
  localparam logic [OCC_W-1:0] IdxP1C = OCC_W'(IDX + 1);

  logic [PAGE_BITS-1:0] page_q, page_d;
  logic                 occupied;
  logic                 shift_en;
  logic                 load_en;

  // Compare the request against this slot when it holds a resident page
  assign occupied = (IdxC < occ_i);
  assign match_o  = occupied && (page_q == page_i);

  // Pass on whether the shift region has started at or below this slot
  assign seen_o = seen_i | match_o;

  // Shift down below the top slot, load the request into the top slot
  assign shift_en = seen_o && (IdxP1C < occ_i);
  assign load_en  = ((ctrl_i.hit || ctrl_i.evict) && (IdxP1C == occ_i)) ||
                    (ctrl_i.append && (IdxC == occ_i));

  always_comb begin
    page_d = page_q;
    if (ctrl_i.en) begin
      if (load_en) begin
        page_d = page_i;
      end else if (shift_en) begin
        page_d = upper_page_i;
      end
    end
  end

  // Hold page contents; occupancy in the top level says which are live
  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  assign page_o = page_q;

endmodule

// File: rtl/core/lru_page_replacement.sv
`timescale 1ns / 1ps

// LRU page replacement engine.
// Requests: drive page_number_i and last_reference_i with start high; a
// request is taken at any rising edge where start is high and busy is low.
// busy stays low, so a new request may be issued every cycle.
// Results: one per request, on the result ports for one cycle with
// result_valid_o high, in the cycle after the request is taken.
// Throughput is one request per cycle; that figure is set by the row of
// FRAMES cells, which compare and shift all slots in the same cycle, with
// the hit position rippling through the cell chain.
// Configuration: frame_count_we_i writes frame_count_wdata_i into the frame
// limit; write only while no request is in flight. 0 acts as 1, values
// above FRAMES act as FRAMES.
// A request with last_reference_i set returns its result, then empties the
// stack and clears the fault count. Reset does the same and sets the frame
// limit to 3. Results cannot be held off by the receiver.
module lru_page_replacement #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 8,
  localparam int unsigned OCC_W    = $clog2(FRAMES + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  frame_count_we_i,
  input  logic [lru_pr_pkg::FrameCountW-1:0]    frame_count_wdata_i,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [PAGE_BITS-1:0]                  page_number_i,
  input  logic                                  last_reference_i,
  output logic                                  result_valid_o,
  output logic                                  fault_o,
  output logic                                  evicted_valid_o,
  output logic [PAGE_BITS-1:0]                  evicted_page_o,
  output logic [OCC_W-1:0]                      resident_count_o,
  output logic [lru_pr_pkg::FaultCountW-1:0]    fault_count_o
);
  import lru_pr_pkg::*;

  localparam int unsigned CMP_W = (OCC_W > FrameCountW) ? OCC_W : FrameCountW;
  localparam logic [CMP_W-1:0] FramesC = CMP_W'(FRAMES);
  localparam logic [CMP_W-1:0] OneC    = CMP_W'(1);
  localparam logic [FaultCountW-1:0] FaultMax = '1;

  logic [FrameCountW-1:0] frame_count_q;
  logic [OCC_W-1:0]       occ_q, occ_d, occ_upd;
  logic [FaultCountW-1:0] fault_total_q, fault_total_d, fault_upd;

  logic                   valid_q;
  logic                   fault_q, ev_valid_q;
  logic [PAGE_BITS-1:0]   ev_page_q;
  logic [OCC_W-1:0]       res_cnt_q;
  logic [FaultCountW-1:0] fault_cnt_q;

  logic                   accept;
  logic [CMP_W-1:0]       fc_ext, limit, occ_ext;
  logic                   hit, evict, append;
  lru_ctrl_t              ctrl;

  logic [PAGE_BITS-1:0]   cell_page [FRAMES];
  logic [PAGE_BITS-1:0]   upper_page [FRAMES];
  logic [FRAMES:0]        seen;
  logic [FRAMES-1:0]      match;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Clamp the configured frame count into 1..FRAMES
  assign fc_ext = CMP_W'(frame_count_q);
  always_comb begin
    limit = fc_ext;
    if (fc_ext == '0) begin
      limit = OneC;
    end else if (fc_ext > FramesC) begin
      limit = FramesC;
    end
  end

  // Classify the request
  assign occ_ext = CMP_W'(occ_q);
  assign hit     = |match;
  assign evict   = !hit && (occ_ext >= limit);
  assign append  = !hit && !evict;

  assign ctrl.en     = accept;
  assign ctrl.hit    = hit;
  assign ctrl.evict  = evict;
  assign ctrl.append = append;

  // Row of recency cells, slot 0 least recent
  assign seen[0] = evict;
  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    if (i + 1 < FRAMES) begin : g_upper
      assign upper_page[i] = cell_page[i+1];
    end else begin : g_top
      assign upper_page[i] = '0;
    end

    lru_pr_cell #(
      .PAGE_BITS (PAGE_BITS),
      .OCC_W     (OCC_W),
      .IDX       (i)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .page_i       (page_number_i),
      .occ_i        (occ_q),
      .upper_page_i (upper_page[i]),
      .seen_i       (seen[i]),
      .seen_o       (seen[i+1]),
      .match_o      (match[i]),
      .page_o       (cell_page[i])
    );
  end

  // Advance occupancy and the saturating fault count
  assign occ_upd   = append ? occ_q + OCC_W'(1) : occ_q;
  assign fault_upd = (!hit && (fault_total_q != FaultMax)) ?
                     fault_total_q + FaultCountW'(1) : fault_total_q;

  always_comb begin
    occ_d         = occ_q;
    fault_total_d = fault_total_q;
    if (accept) begin
      occ_d         = last_reference_i ? '0 : occ_upd;
      fault_total_d = last_reference_i ? '0 : fault_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FrameCountReset;
      occ_q         <= '0;
      fault_total_q <= '0;
      valid_q       <= 1'b0;
    end else begin
      if (frame_count_we_i) begin
        frame_count_q <= frame_count_wdata_i;
      end
      occ_q         <= occ_d;
      fault_total_q <= fault_total_d;
      valid_q       <= accept;
    end
  end

  // Register the result of the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fault_q     <= !hit;
      ev_valid_q  <= evict;
      ev_page_q   <= evict ? cell_page[0] : '0;
      res_cnt_q   <= occ_upd;
      fault_cnt_q <= fault_upd;
    end
  end

  assign result_valid_o   = valid_q;
  assign fault_o          = fault_q;
  assign evicted_valid_o  = ev_valid_q;
  assign evicted_page_o   = ev_page_q;
  assign resident_count_o = res_cnt_q;
  assign fault_count_o    = fault_cnt_q;

endmodule

// File: rtl/core/lru_pr_checker.sv
`timescale 1ns / 1ps

module lru_pr_checker #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 8,
  localparam int unsigned OCC_W    = $clog2(FRAMES + 1)
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic                               result_valid_o,
  input logic                               fault_o,
  input logic                               evicted_valid_o,
  input logic [PAGE_BITS-1:0]               evicted_page_o,
  input logic [OCC_W-1:0]                   resident_count_o,
  input logic [lru_pr_pkg::FaultCountW-1:0] fault_count_o
);
  import lru_pr_pkg::*;

  localparam logic [OCC_W-1:0] FramesC = OCC_W'(FRAMES);

  // Every request yields exactly one result in the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> result_valid_o)
    else $error("request without result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !result_valid_o)
    else $error("result without request");

  // An eviction only happens on a fault, and the fault count is then non-zero
  a_evict_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && evicted_valid_o) |-> (fault_o && (fault_count_o != '0)))
    else $error("eviction without counted fault");

  // Evicted page reads zero when nothing is evicted
  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !evicted_valid_o) |-> (evicted_page_o == '0))
    else $error("stale evicted page");

  // Occupancy never exceeds the built frame count
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (resident_count_o <= FramesC))
    else $error("occupancy above frame count");

endmodule

bind lru_page_replacement lru_pr_checker #(
  .FRAMES    (FRAMES),
  .PAGE_BITS (PAGE_BITS)
) u_lru_pr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .result_valid_o   (result_valid_o),
  .fault_o          (fault_o),
  .evicted_valid_o  (evicted_valid_o),
  .evicted_page_o   (evicted_page_o),
  .resident_count_o (resident_count_o),
  .fault_count_o    (fault_count_o)
);
